// ===== hw/rtl/cdhi_pkg.sv =====
// ----------------------------------------------------------------------------
// cdhi_pkg: CD-ROM host interface shared definitions
// Types, codes and sizes used by the host register interface modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdhi_pkg;

    // FIFO sizes
    localparam int PARAM_DEPTH    = 16;
    localparam int RESPONSE_DEPTH = 16;

    localparam int PARAM_IDX_W = $clog2(PARAM_DEPTH);
    localparam int PARAM_CNT_W = $clog2(PARAM_DEPTH + 1);
    localparam int RESP_PTR_W  = $clog2(RESPONSE_DEPTH);
    localparam int RESP_LEN_W  = $clog2(RESPONSE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_STATUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 1'b1;

    localparam logic [7:0]  DRIVE_STATUS_RST = 8'h12;
    localparam logic [31:0] VERSION_RST      = 32'h9806_10C3;

    // Host access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Byte ports
    localparam logic [1:0] PORT_STATUS = 2'd0;
    localparam logic [1:0] PORT_CMD    = 2'd1;
    localparam logic [1:0] PORT_PARAM  = 2'd2;
    localparam logic [1:0] PORT_IRQ    = 2'd3;

    localparam logic [1:0] BANK_0 = 2'd0;
    localparam logic [1:0] BANK_1 = 2'd1;

    // Commands
    localparam logic [7:0] CMD_GETSTAT   = 8'h01;
    localparam logic [7:0] CMD_TEST      = 8'h19;
    localparam logic [7:0] TEST_VERSION  = 8'h20;

    // Interrupt codes
    localparam logic [4:0] IRQ_ACK   = 5'd3;
    localparam logic [4:0] IRQ_ERROR = 5'd5;
    localparam logic [4:0] IRQ_MASK  = 5'h1f;
    localparam logic [2:0] IRQ_RD_PAD = 3'b111;

    localparam int SHELL_OPEN_BIT = 4;

    // FIFO status bit positions
    localparam int ST_EMPTY = 0;
    localparam int ST_READY = 1;
    localparam int ST_RESP  = 2;

    typedef struct packed {
        logic       opcode;
        logic [1:0] port;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
    } t_result;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/cdhi_intf.sv =====
// ----------------------------------------------------------------------------
// cdhi_intf: CD-ROM host interface channel interfaces
// Valid/ready channels for host accesses, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdhi_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [1:0] port;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output port, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input port, input write_data,
                    output ready);
endinterface

interface cdhi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_request;

    modport source (output valid, output read_data, output irq_request, input ready);
    modport sink   (input valid, input read_data, input irq_request, output ready);
endinterface

interface cdhi_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cdhi_in_stage.sv =====
// ----------------------------------------------------------------------------
// cdhi_in_stage: input register
// Holds one accepted host access until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdhi_in_stage
    import cdhi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_out_free,   // result register can load this cycle
    output logic       o_fire,       // word handed to core
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_fire  = r_valid && i_out_free;
    assign o_ready = !r_valid || o_fire;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cdhi_core.sv =====
// ----------------------------------------------------------------------------
// cdhi_core: register file and command logic
// Bank, FIFOs, interrupt registers; one access processed per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module cdhi_core
    import cdhi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg_wr,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output t_result      o_result
);

    // config
    logic [7:0]  r_drive_status;
    logic [31:0] r_version;

    // control state
    logic [1:0]             r_bank,        n_bank;
    logic [2:0]             r_fifo_st,     n_fifo_st;
    logic [PARAM_CNT_W-1:0] r_param_count, n_param_count;
    logic [RESP_LEN_W-1:0]  r_resp_len,    n_resp_len;
    logic [RESP_PTR_W-1:0]  r_resp_ptr,    n_resp_ptr;
    logic [4:0]             r_irq_flags,   n_irq_flags;
    logic [4:0]             r_irq_en,      n_irq_en;
    logic [7:0]             r_request,     n_request;
    logic                   r_shell_clr,   n_shell_clr;

    // stores, no reset
    logic [7:0] r_param_mem [PARAM_DEPTH];
    logic [7:0] r_resp_mem  [RESPONSE_DEPTH];

    logic                  param_wr;
    logic                  resp_wr_stat;
    logic                  resp_wr_ver;
    logic [7:0]            stat_byte;
    logic [RESP_LEN_W-1:0] ptr_inc;
    logic                  is_cmd;
    logic                  is_getstat;
    logic                  is_test_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_status <= DRIVE_STATUS_RST;
            r_version      <= VERSION_RST;
        end else if (i_cfg_wr.en) begin
            unique case (i_cfg_wr.index)
                CFG_DRIVE_STATUS: r_drive_status <= i_cfg_wr.data[7:0];
                CFG_VERSION:      r_version      <= i_cfg_wr.data;
                default:          ;
            endcase
        end
    end

    assign is_cmd     = (i_item.opcode == OP_WRITE) && (i_item.port == PORT_CMD)
                        && (r_bank == BANK_0);
    assign is_getstat = is_cmd && (i_item.write_data == CMD_GETSTAT);
    assign is_test_ok = is_cmd && (i_item.write_data == CMD_TEST)
                        && (r_param_count == PARAM_CNT_W'(1))
                        && (r_param_mem[0] == TEST_VERSION);

    always_comb begin
        stat_byte = r_drive_status;
        if (r_shell_clr) begin
            stat_byte[SHELL_OPEN_BIT] = 1'b0;
        end
    end

    assign ptr_inc = RESP_LEN_W'(r_resp_ptr) + RESP_LEN_W'(1);

    always_comb begin
        n_bank        = r_bank;
        n_fifo_st     = r_fifo_st;
        n_param_count = r_param_count;
        n_resp_len    = r_resp_len;
        n_resp_ptr    = r_resp_ptr;
        n_irq_flags   = r_irq_flags;
        n_irq_en      = r_irq_en;
        n_request     = r_request;
        n_shell_clr   = r_shell_clr;
        param_wr      = 1'b0;
        resp_wr_stat  = 1'b0;
        resp_wr_ver   = 1'b0;
        o_result      = '0;

        if (i_item.opcode == OP_READ) begin
            case (i_item.port)
                PORT_STATUS: o_result.read_data = {2'b00, r_fifo_st, 1'b0, r_bank};
                PORT_CMD: begin
                    o_result.read_data = r_resp_mem[r_resp_ptr];
                    if (ptr_inc >= r_resp_len) begin
                        n_fifo_st[ST_RESP] = 1'b0;
                    end
                    if (ptr_inc == RESP_LEN_W'(RESPONSE_DEPTH)) begin
                        n_resp_ptr = '0;
                    end else begin
                        n_resp_ptr = ptr_inc[RESP_PTR_W-1:0];
                    end
                end
                PORT_IRQ: begin
                    if (!r_bank[0]) begin
                        o_result.read_data = {3'b000, r_irq_en};
                    end else begin
                        o_result.read_data = {IRQ_RD_PAD, r_irq_flags};
                    end
                end
                default: ;
            endcase
        end else begin
            case (i_item.port)
                PORT_STATUS: n_bank = i_item.write_data[1:0];
                PORT_CMD: begin
                    if (r_bank == BANK_0) begin
                        // command completion
                        n_param_count       = '0;
                        n_resp_ptr          = '0;
                        n_fifo_st[ST_EMPTY] = 1'b1;
                        n_fifo_st[ST_READY] = 1'b1;
                        if (is_getstat) begin
                            resp_wr_stat      = 1'b1;
                            n_resp_len        = RESP_LEN_W'(1);
                            n_shell_clr       = 1'b1;
                            n_irq_flags       = r_irq_flags | IRQ_ACK;
                            n_fifo_st[ST_RESP] = 1'b1;
                        end else if (is_test_ok) begin
                            resp_wr_ver       = 1'b1;
                            n_resp_len        = RESP_LEN_W'(4);
                            n_irq_flags       = r_irq_flags | IRQ_ACK;
                            n_fifo_st[ST_RESP] = 1'b1;
                        end else begin
                            n_resp_len        = '0;
                            n_irq_flags       = r_irq_flags | IRQ_ERROR;
                            n_fifo_st[ST_RESP] = 1'b0;
                        end
                        o_result.irq_request = |(n_irq_flags & r_irq_en);
                    end
                end
                PORT_PARAM: begin
                    if (r_bank == BANK_0) begin
                        if (r_param_count < PARAM_CNT_W'(PARAM_DEPTH)) begin
                            param_wr            = 1'b1;
                            n_param_count       = r_param_count + PARAM_CNT_W'(1);
                            n_fifo_st[ST_EMPTY] = 1'b0;
                            if (n_param_count == PARAM_CNT_W'(PARAM_DEPTH)) begin
                                n_fifo_st[ST_READY] = 1'b0;
                            end
                        end
                    end else if (r_bank == BANK_1) begin
                        n_irq_en = i_item.write_data[4:0] & IRQ_MASK;
                    end
                end
                default: begin
                    if (r_bank == BANK_0) begin
                        n_request = i_item.write_data;
                    end else if (r_bank[0]) begin
                        n_irq_flags = r_irq_flags & ~i_item.write_data[4:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank        <= '0;
            r_fifo_st     <= 3'b011;
            r_param_count <= '0;
            r_resp_len    <= '0;
            r_resp_ptr    <= '0;
            r_irq_flags   <= '0;
            r_irq_en      <= '0;
            r_request     <= '0;
            r_shell_clr   <= 1'b0;
        end else if (i_fire) begin
            r_bank        <= n_bank;
            r_fifo_st     <= n_fifo_st;
            r_param_count <= n_param_count;
            r_resp_len    <= n_resp_len;
            r_resp_ptr    <= n_resp_ptr;
            r_irq_flags   <= n_irq_flags;
            r_irq_en      <= n_irq_en;
            r_request     <= n_request;
            r_shell_clr   <= n_shell_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && param_wr) begin
            r_param_mem[r_param_count[PARAM_IDX_W-1:0]] <= i_item.write_data;
        end
        if (i_fire && resp_wr_stat) begin
            r_resp_mem[0] <= stat_byte;
        end
        if (i_fire && resp_wr_ver) begin
            r_resp_mem[0] <= r_version[31:24];
            r_resp_mem[1] <= r_version[23:16];
            r_resp_mem[2] <= r_version[15:8];
            r_resp_mem[3] <= r_version[7:0];
        end
    end

    // empty flag tracks the parameter count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_st[ST_EMPTY] == (r_param_count == '0))
        else $error("param empty flag out of step with count");

    // ready flag drops only when the parameter FIFO is full
    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_st[ST_READY] == (r_param_count != PARAM_CNT_W'(PARAM_DEPTH)))
        else $error("param ready flag out of step with count");

    // pending response means the pointer has not passed the length
    a_resp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_st[ST_RESP] |-> (RESP_LEN_W'(r_resp_ptr) < r_resp_len))
        else $error("response flag set with pointer past length");

    // a command empties the parameter FIFO
    a_cmd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && is_cmd) |=> (r_param_count == '0))
        else $error("parameter FIFO not cleared by command");

endmodule

`default_nettype wire

// ===== hw/rtl/cdhi_out_stage.sv =====
// ----------------------------------------------------------------------------
// cdhi_out_stage: result register
// Holds one result word until the host side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdhi_out_stage
    import cdhi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cdrom_controller_host_interface_unit.sv =====
// ----------------------------------------------------------------------------
// cdrom_controller_host_interface_unit: CD-ROM controller host registers
// Four byte ports behind a bank index; parameter and response FIFOs,
// interrupt flags and enables, Getstat and Test version commands.
// ----------------------------------------------------------------------------
// Path: an accepted access word passes the input register, the core logic
//   and the result register. Throughput: one access word per cycle while the
//   result register is free; the core updates all of its state in one pass per word.
// Reset (i_rst_n, synchronous, active low): clears valids, bank, FIFO
//   counts, interrupt registers and restores config defaults; the FIFO
//   stores are not cleared and hold unknown data until written.
`default_nettype none

module cdrom_controller_host_interface_unit
    import cdhi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdhi_in_if.sink    i_item,
    cdhi_out_if.source o_result,
    cdhi_cfg_if.sink   i_cfg
);

    t_item   in_item;
    t_item   core_item;
    t_result core_result;
    t_result out_result;
    t_cfg_wr cfg_wr;
    logic    fire;
    logic    out_free;

    // config writes are taken at once
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    assign in_item.opcode     = i_item.opcode;
    assign in_item.port       = i_item.port;
    assign in_item.write_data = i_item.write_data;

    // input register
    cdhi_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_item.valid),
        .o_ready    (i_item.ready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_item     (core_item)
    );

    // state and command logic, single pass per word
    cdhi_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_fire   (fire),
        .i_item   (core_item),
        .o_result (core_result)
    );

    // result register, free while empty or while the sink takes the current word
    cdhi_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (out_result)
    );

    assign o_result.read_data   = out_result.read_data;
    assign o_result.irq_request = out_result.irq_request;

endmodule

`default_nettype wire

// ===== bench/cdrom_controller_host_interface_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cdrom_controller_host_interface_unit_tb: self-checking bench for the host regs
// Drives host read/write words into the four byte ports and checks each result
// word against a cycle-free model of the banks, FIFOs, commands and IRQ logic.
// Directed cases come first, then random command sequences under several
// register settings, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrom_controller_host_interface_unit_tb;
    import cdhi_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int TIMEOUT_CYC  = 400000;
    localparam int RANDOM_WORDS = 1150;
    localparam int N_SETTINGS   = 5;
    localparam int DRAIN_CYC    = 4;   // margin past the input and result registers

    localparam logic [1:0] BANK_2 = 2'd2;
    localparam logic [1:0] BANK_3 = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    cdhi_in_if  host_if ();
    cdhi_out_if reply_if ();
    cdhi_cfg_if cfg_if ();

    cdrom_controller_host_interface_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (host_if),
        .o_result (reply_if),
        .i_cfg    (cfg_if)
    );

    // ------------------------------------------------------------------
    // Model of the controller registers, updated on every accepted word
    // ------------------------------------------------------------------
    logic [7:0]             mdl_drive_status;
    logic [31:0]            mdl_version;
    logic [1:0]             mdl_bank;
    logic [2:0]             mdl_fifo_st;
    logic [7:0]             mdl_params [PARAM_DEPTH];
    logic [PARAM_CNT_W-1:0] mdl_param_cnt;
    logic [7:0]             mdl_resp [RESPONSE_DEPTH];
    bit                     resp_filled [RESPONSE_DEPTH];
    logic [RESP_LEN_W-1:0]  mdl_resp_len;
    // one bit wider than the slot index: the pointer touches DEPTH before wrapping
    logic [RESP_LEN_W-1:0]  mdl_resp_ptr;
    logic [4:0]             mdl_irq_flags;
    logic [4:0]             mdl_irq_en;
    logic [7:0]             mdl_request;
    bit                     mdl_shell_cleared;

    t_result expected_replies [$];

    int err_cnt;
    int n_words_in;
    int n_words_out;
    int n_effective;      // words that touch some register
    int n_commands;
    int n_resp_reads;
    int n_param_drops;
    int n_cfg_writes;
    int sink_wait;        // stall cycles left before the next reply is taken
    bit idle_on;

    // Computes the reply word of one host access and advances the model.
    function automatic t_result predict_access(input t_item it);
        t_result    r;
        logic [7:0] st;
        logic [4:0] code;
        bit         hit;
        int         i;
        r   = '0;
        hit = 1'b1;
        if (it.opcode == OP_READ) begin
            case (it.port)
                PORT_STATUS: r.read_data = {2'b00, mdl_fifo_st, 1'b0, mdl_bank};
                PORT_CMD: begin
                    r.read_data = mdl_resp[mdl_resp_ptr[RESP_PTR_W-1:0]];
                    mdl_resp_ptr++;
                    n_resp_reads++;
                    if (mdl_resp_ptr >= mdl_resp_len) mdl_fifo_st[ST_RESP] = 1'b0;
                    if (mdl_resp_ptr >= RESPONSE_DEPTH) mdl_resp_ptr = '0;
                end
                PORT_IRQ: begin
                    r.read_data = mdl_bank[0] ? {IRQ_RD_PAD, mdl_irq_flags}
                                              : {3'b000, mdl_irq_en};
                end
                default: hit = 1'b0;
            endcase
        end else begin
            case (it.port)
                PORT_STATUS: mdl_bank = it.write_data[1:0];
                PORT_CMD: begin
                    if (mdl_bank == BANK_0) begin
                        code         = IRQ_ERROR;
                        mdl_resp_len = '0;
                        n_commands++;
                        if (it.write_data == CMD_GETSTAT) begin
                            // shell-open bit reads back once only
                            st = mdl_drive_status;
                            if (mdl_shell_cleared) st[SHELL_OPEN_BIT] = 1'b0;
                            mdl_resp[0]       = st;
                            resp_filled[0]    = 1'b1;
                            mdl_resp_len      = RESP_LEN_W'(1);
                            mdl_shell_cleared = 1'b1;
                            code              = IRQ_ACK;
                        end else if (it.write_data == CMD_TEST && mdl_param_cnt == 1 &&
                                     mdl_params[0] == TEST_VERSION) begin
                            for (i = 0; i < 4; i++) begin
                                mdl_resp[i]    = mdl_version[8*(3-i) +: 8];
                                resp_filled[i] = 1'b1;
                            end
                            mdl_resp_len = RESP_LEN_W'(4);
                            code         = IRQ_ACK;
                        end
                        mdl_resp_ptr          = '0;
                        mdl_param_cnt         = '0;
                        mdl_fifo_st[ST_EMPTY] = 1'b1;
                        mdl_fifo_st[ST_READY] = 1'b1;
                        mdl_irq_flags         = (mdl_irq_flags | code) & IRQ_MASK;
                        mdl_fifo_st[ST_RESP]  = (mdl_resp_len != 0);
                        r.irq_request         = (mdl_irq_flags & mdl_irq_en) != 0;
                    end else begin
                        hit = 1'b0;
                    end
                end
                PORT_PARAM: begin
                    if (mdl_bank == BANK_0) begin
                        if (mdl_param_cnt < PARAM_DEPTH) begin
                            mdl_params[mdl_param_cnt[PARAM_IDX_W-1:0]] = it.write_data;
                            mdl_param_cnt++;
                            mdl_fifo_st[ST_EMPTY] = 1'b0;
                            if (mdl_param_cnt >= PARAM_DEPTH) mdl_fifo_st[ST_READY] = 1'b0;
                        end else begin
                            n_param_drops++;
                        end
                    end else if (mdl_bank == BANK_1) begin
                        mdl_irq_en = it.write_data[4:0] & IRQ_MASK;
                    end else begin
                        hit = 1'b0;
                    end
                end
                default: begin
                    if (mdl_bank == BANK_0) begin
                        mdl_request = it.write_data;
                    end else if (mdl_bank[0]) begin
                        mdl_irq_flags = mdl_irq_flags & ~(it.write_data[4:0] & IRQ_MASK);
                    end else begin
                        hit = 1'b0;
                    end
                end
            endcase
        end
        if (hit) n_effective++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: every handshake is seen here at the rising edge. The host
    // word is predicted before the reply is checked so ordering holds.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_item   acc;
        t_result exp_r;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                n_cfg_writes++;
                if (cfg_if.index == CFG_DRIVE_STATUS) mdl_drive_status = cfg_if.data[7:0];
                else                                  mdl_version      = cfg_if.data;
            end
            if (host_if.valid && host_if.ready) begin
                acc.opcode     = host_if.opcode;
                acc.port       = host_if.port;
                acc.write_data = host_if.write_data;
                expected_replies.push_back(predict_access(acc));
                n_words_in++;
            end
            if (reply_if.valid && reply_if.ready) begin
                n_words_out++;
                if (expected_replies.size() == 0) begin
                    $error("reply word with nothing expected: read_data %h irq_request %b",
                           reply_if.read_data, reply_if.irq_request);
                    err_cnt++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (reply_if.read_data !== exp_r.read_data) begin
                        $error("read_data: expected %h, got %h",
                               exp_r.read_data, reply_if.read_data);
                        err_cnt++;
                    end
                    if (reply_if.irq_request !== exp_r.irq_request) begin
                        $error("irq_request: expected %b, got %b",
                               exp_r.irq_request, reply_if.irq_request);
                        err_cnt++;
                    end
                end
                sink_wait = idle_on ? $urandom_range(0, 3) : 0;
            end
        end
    end

    // Reply side: stall for the drawn number of cycles, then take a word.
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            reply_if.ready = 1'b0;
            sink_wait--;
        end else begin
            reply_if.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one host word. Called at a falling edge; returns at the falling
    // edge after acceptance with valid still high, so back-to-back words with
    // no idle gap drawn keep valid high in between.
    task automatic host_access(input logic op, input logic [1:0] port,
                               input logic [7:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        // response slots never filled by a command stay off limits
        if (op == OP_READ && port == PORT_CMD &&
            !resp_filled[mdl_resp_ptr[RESP_PTR_W-1:0]])
            port = PORT_PARAM;
        if (gap > 0) begin
            host_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        host_if.opcode     = op;
        host_if.port       = port;
        host_if.write_data = data;
        host_if.valid      = 1'b1;
        do @(posedge i_clk); while (!host_if.ready);
        @(negedge i_clk);
    endtask

    // Holds the host side off until every reply has come back or the limit runs out.
    task automatic drain(input int limit);
        int n;
        n = 0;
        host_if.valid = 1'b0;
        while (expected_replies.size() != 0 && n < limit) begin
            @(negedge i_clk);
            n++;
        end
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_if.index = idx;
        cfg_if.data  = val;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 2))
            0:       return CMD_GETSTAT;
            1:       return CMD_TEST;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Reset status, then Getstat twice: shell-open bit seen once only.
    task automatic test_getstat_shell();
        host_access(OP_READ,  PORT_STATUS, 8'h00);
        host_access(OP_WRITE, PORT_CMD,    CMD_GETSTAT);
        host_access(OP_READ,  PORT_CMD,    8'hff);
        host_access(OP_WRITE, PORT_CMD,    CMD_GETSTAT);
        host_access(OP_READ,  PORT_CMD,    8'h00);
    endtask

    // Enables, flag readback with pad bits, flag clear, unsupported read.
    task automatic test_irq_regs();
        host_access(OP_WRITE, PORT_STATUS, {6'h3f, BANK_1});
        host_access(OP_WRITE, PORT_PARAM,  8'hff);
        host_access(OP_READ,  PORT_IRQ,    8'h00);
        host_access(OP_WRITE, PORT_IRQ,    8'h01);
        host_access(OP_READ,  PORT_PARAM,  8'h00);
        host_access(OP_WRITE, PORT_STATUS, {6'h00, BANK_0});
        host_access(OP_READ,  PORT_IRQ,    8'h00);
    endtask

    // Test with the version sub-function, all four bytes read out.
    task automatic test_version();
        int i;
        host_access(OP_WRITE, PORT_PARAM, TEST_VERSION);
        host_access(OP_WRITE, PORT_CMD,   CMD_TEST);
        for (i = 0; i < 4; i++) host_access(OP_READ, PORT_CMD, 8'h00);
    endtask

    // One write past a full parameter FIFO; Test then fails as unknown.
    task automatic test_param_overflow();
        int i;
        host_access(OP_WRITE, PORT_PARAM, TEST_VERSION);
        for (i = 1; i <= PARAM_DEPTH; i++)
            host_access(OP_WRITE, PORT_PARAM, 8'($urandom_range(0, 255)));
        host_access(OP_READ,  PORT_STATUS, 8'h00);
        host_access(OP_WRITE, PORT_CMD,    CMD_TEST);
        host_access(OP_READ,  PORT_STATUS, 8'h00);
    endtask

    // Register settings per phase: extremes first, random in between,
    // defaults last.
    task automatic test_register_settings(input int phase);
        case (phase)
            0: begin
                write_reg(CFG_DRIVE_STATUS, 32'h0000_00ff);
                write_reg(CFG_VERSION,      32'hffff_ffff);
            end
            1: begin
                write_reg(CFG_DRIVE_STATUS, 32'h0000_0000);
                write_reg(CFG_VERSION,      32'h0000_0000);
            end
            N_SETTINGS - 1: begin
                write_reg(CFG_DRIVE_STATUS, {24'h0, DRIVE_STATUS_RST});
                write_reg(CFG_VERSION,      VERSION_RST);
            end
            default: begin
                write_reg(CFG_DRIVE_STATUS, {24'h0, 8'($urandom_range(0, 255))});
                write_reg(CFG_VERSION,      $urandom);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed command sequences, some noise
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int budget);
        int start;
        int i;
        int n;
        start = n_words_in;
        while (n_words_in - start < budget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // Getstat and its status byte
                    host_access(OP_WRITE, PORT_STATUS, {6'($urandom), BANK_0});
                    host_access(OP_WRITE, PORT_CMD,    CMD_GETSTAT);
                    if ($urandom_range(0, 1)) host_access(OP_READ, PORT_STATUS, 8'h00);
                    n = $urandom_range(0, 2);
                    for (i = 0; i < n; i++) host_access(OP_READ, PORT_CMD, 8'($urandom));
                end
                2, 3: begin
                    // version query, sometimes read past the end
                    host_access(OP_WRITE, PORT_STATUS, {6'($urandom), BANK_0});
                    host_access(OP_WRITE, PORT_PARAM,  TEST_VERSION);
                    host_access(OP_WRITE, PORT_CMD,    CMD_TEST);
                    n = $urandom_range(0, 5);
                    for (i = 0; i < n; i++) begin
                        host_access(OP_READ, PORT_CMD, 8'($urandom));
                        if ($urandom_range(0, 3) == 0) host_access(OP_READ, PORT_STATUS, 8'h00);
                    end
                end
                4: begin
                    // Test or another command after a random parameter list
                    host_access(OP_WRITE, PORT_STATUS, {6'($urandom), BANK_0});
                    n = $urandom_range(0, 3);
                    for (i = 0; i < n; i++)
                        host_access(OP_WRITE, PORT_PARAM,
                                    $urandom_range(0, 1) ? TEST_VERSION : 8'($urandom));
                    host_access(OP_WRITE, PORT_CMD, $urandom_range(0, 1) ? CMD_TEST
                                                                         : pick_command());
                    if ($urandom_range(0, 1)) host_access(OP_READ, PORT_CMD, 8'h00);
                end
                5: begin
                    // interrupt enables and flags in the odd banks
                    host_access(OP_WRITE, PORT_STATUS,
                                {6'($urandom), $urandom_range(0, 1) ? BANK_1 : BANK_3});
                    host_access(OP_WRITE, PORT_PARAM, 8'($urandom));
                    host_access(OP_READ,  PORT_IRQ,   8'h00);
                    host_access(OP_WRITE, PORT_IRQ,   8'($urandom));
                    host_access(OP_READ,  PORT_IRQ,   8'h00);
                    host_access(OP_WRITE, PORT_STATUS, {6'($urandom), BANK_0});
                    host_access(OP_READ,  PORT_IRQ,   8'h00);
                    host_access(OP_WRITE, PORT_CMD,   pick_command());
                end
                6: begin
                    // parameter FIFO near, at and past full
                    host_access(OP_WRITE, PORT_STATUS, {6'($urandom), BANK_0});
                    n = $urandom_range(PARAM_DEPTH - 4, PARAM_DEPTH + 2);
                    for (i = 0; i < n; i++) host_access(OP_WRITE, PORT_PARAM, 8'($urandom));
                    host_access(OP_READ,  PORT_STATUS, 8'h00);
                    host_access(OP_WRITE, PORT_CMD,    pick_command());
                end
                7, 8: begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        host_access(1'($urandom), 2'($urandom), 8'($urandom));
                end
                default: begin
                    // now and then the host waits for every reply
                    if ($urandom_range(0, 4) == 0) drain(1000);
                    else host_access(1'($urandom), 2'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        i_rst_n            = 1'b0;
        host_if.valid      = 1'b0;
        host_if.opcode     = OP_READ;
        host_if.port       = PORT_STATUS;
        host_if.write_data = 8'h00;
        reply_if.ready     = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_DRIVE_STATUS;
        cfg_if.data        = 32'h0;
        idle_on            = 1'b1;
        sink_wait          = 0;
        err_cnt            = 0;

        // model state after reset; stores left unfilled
        mdl_drive_status  = DRIVE_STATUS_RST;
        mdl_version       = VERSION_RST;
        mdl_bank          = BANK_0;
        mdl_fifo_st       = 3'b011;
        mdl_param_cnt     = '0;
        mdl_resp_len      = '0;
        mdl_resp_ptr      = '0;
        mdl_irq_flags     = '0;
        mdl_irq_en        = '0;
        mdl_request       = '0;
        mdl_shell_cleared = 1'b0;
        foreach (resp_filled[k]) resp_filled[k] = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_getstat_shell();
        test_irq_regs();
        test_version();
        test_param_overflow();
        drain(1000);

        // registers only change with the block idle
        for (phase = 0; phase < N_SETTINGS; phase++) begin
            test_register_settings(phase);
            test_random_traffic(RANDOM_WORDS / N_SETTINGS);
            drain(1000);
        end

        drain(2000);
        if (expected_replies.size() != 0) begin
            $error("%0d expected reply words never arrived", expected_replies.size());
            err_cnt++;
        end

        $display("Covered %0d host words (%0d touching registers), %0d replies checked",
                 n_words_in, n_effective, n_words_out);
        $display("  %0d commands, %0d response reads, %0d dropped params, %0d reg writes",
                 n_commands, n_resp_reads, n_param_drops, n_cfg_writes);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYC);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
